// File: src/srm_pkg.sv
package srm_pkg;

	localparam int MAX_PATTERN = 8;
	localparam int IDX_W       = $clog2(MAX_PATTERN);
	localparam int CNT_W       = $clog2(MAX_PATTERN + 1);

	localparam logic [7:0] MARK_BYTE = 8'd42;

	// configuration register indexes
	localparam logic CFG_PATTERN_BYTES = 1'b0;
	localparam logic CFG_PATTERN_LEN   = 1'b1;

	typedef logic [7:0] char_t;

	// one queued request: the result bytes that one input byte causes
	typedef struct packed {
		char_t [MAX_PATTERN-1:0] bytes;
		logic [CNT_W-1:0]        n;
		logic                    last;
	} entry_t;

endpackage

// File: src/srm_ifs.sv
interface srm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       in_last;
	modport source(output valid, in_char, in_last, input ready);
	modport sink(input valid, in_char, in_last, output ready);
endinterface

interface srm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       out_last;
	modport source(output valid, out_char, out_last, input ready);
	modport sink(input valid, out_char, out_last, output ready);
endinterface

interface srm_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [63:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: src/srm_queue.sv
module srm_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  srm_pkg::entry_t push_data,
	output logic            full,
	input  logic            pop,
	output logic            head_valid,
	output srm_pkg::entry_t head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	srm_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/srm_front.sv
module srm_front (
	input  logic            clk,
	input  logic            arst_n,
	srm_in_if.sink          feed,
	srm_cfg_if.sink         cfg,
	input  logic            q_full,
	output logic            push,
	output srm_pkg::entry_t push_data
);

	localparam int MAXP  = srm_pkg::MAX_PATTERN;
	localparam int IDX_W = srm_pkg::IDX_W;
	localparam int CNT_W = srm_pkg::CNT_W;

	logic [63:0]      pattern_q;
	logic [3:0]       pattern_len_q;
	srm_pkg::char_t   window_q [MAXP];
	logic [CNT_W-1:0] count_q;

	srm_pkg::char_t   win [MAXP];
	srm_pkg::char_t   sh [MAXP];
	logic [CNT_W-1:0] cnt1;
	logic [CNT_W-1:0] cnt2;
	logic [CNT_W-1:0] len;
	logic [CNT_W-1:0] drop;
	logic [CNT_W-1:0] flush_n;
	logic             match;
	logic             decide;
	srm_pkg::char_t   dec_char;
	logic             accept;

	assign cfg.ready  = 1'b1;
	assign feed.ready = !q_full;
	assign accept     = feed.valid && !q_full;

	always_comb begin
		int j;
		win  = window_q;
		cnt1 = count_q;
		// append the new byte
		if (count_q < CNT_W'(MAXP)) begin
			win[count_q[IDX_W-1:0]] = feed.in_char;
			cnt1 = count_q + 1'b1;
		end

		len = (pattern_len_q > 4'(MAXP)) ? CNT_W'(MAXP) : CNT_W'(pattern_len_q);

		match = 1'b1;
		for (int i = 0; i < MAXP; i++) begin
			if (CNT_W'(i) < len && win[i] != pattern_q[8*i +: 8]) begin
				match = 1'b0;
			end
		end

		decide = (len == '0) || (cnt1 >= len);
		if (len == '0) begin
			drop     = CNT_W'(1);
			dec_char = win[0];
		end else if (decide && match) begin
			drop     = len;
			dec_char = srm_pkg::MARK_BYTE;
		end else if (decide) begin
			drop     = CNT_W'(1);
			dec_char = win[0];
		end else begin
			drop     = '0;
			dec_char = win[0];
		end

		// drop the consumed front bytes
		for (int k = 0; k < MAXP; k++) begin
			j = k + int'(drop);
			sh[k] = (j < MAXP) ? win[IDX_W'(j)] : '0;
		end
		cnt2 = (drop >= cnt1) ? '0 : cnt1 - drop;

		// decision byte first, then the flushed window on the last byte
		flush_n = feed.in_last ? cnt2 : '0;
		push_data.n    = CNT_W'(decide) + flush_n;
		push_data.last = feed.in_last;
		for (int k = 0; k < MAXP; k++) begin
			if (decide) begin
				push_data.bytes[k] = (k == 0) ? dec_char : sh[(k + MAXP - 1) % MAXP];
			end else begin
				push_data.bytes[k] = sh[k];
			end
		end
	end

	assign push = accept && (push_data.n != '0);

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			pattern_q     <= '0;
			pattern_len_q <= '0;
		end else begin
			if (accept) begin
				count_q <= feed.in_last ? '0 : cnt2;
			end
			if (cfg.valid) begin
				unique case (cfg.index)
					srm_pkg::CFG_PATTERN_BYTES: pattern_q     <= cfg.data;
					srm_pkg::CFG_PATTERN_LEN:   pattern_len_q <= cfg.data[3:0];
					default: ;
				endcase
			end
		end
	end

endmodule

// File: src/srm_back.sv
module srm_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            head_valid,
	input  srm_pkg::entry_t head,
	output logic            pop,
	srm_out_if.source       result
);

	localparam int IDX_W = srm_pkg::IDX_W;
	localparam int CNT_W = srm_pkg::CNT_W;

	logic [IDX_W-1:0] idx_q;
	logic             out_valid_q;
	srm_pkg::char_t   out_char_q;
	logic             out_last_q;
	logic             load;
	logic             final_byte;

	assign result.valid    = out_valid_q;
	assign result.out_char = out_char_q;
	assign result.out_last = out_last_q;

	assign load       = head_valid && (!out_valid_q || result.ready);
	assign final_byte = (CNT_W'(idx_q) == head.n - 1'b1);
	assign pop        = load && final_byte;

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= head.bytes[idx_q];
			out_last_q <= head.last && final_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= final_byte ? '0 : idx_q + 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: src/substring_replace_marker_core.sv
// channel | dir | payload                 | accepted when
// feed    | in  | in_char[7:0], in_last   | feed.valid & feed.ready
// result  | out | out_char[7:0], out_last | result.valid & result.ready
// cfg     | in  | index, data[63:0]       | cfg.valid & cfg.ready (ready always high)
//
// One text byte per cycle enters while the request queue is not full; the window decision
// is made in the accept cycle. Results leave one per cycle from an output register unless
// result.ready holds them back; a byte that ends a line emits up to 8 results.
// The request queue (QUEUE_DEPTH entries) lets input continue while the output drains.
// arst_n clears window count, pattern registers, queue and output valid.
module substring_replace_marker_core #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	srm_in_if.sink    feed,
	srm_out_if.source result,
	srm_cfg_if.sink   cfg
);

	logic            push;
	logic            q_full;
	logic            pop;
	logic            head_valid;
	srm_pkg::entry_t push_data;
	srm_pkg::entry_t head;

	srm_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.push_data(push_data)
	);

	srm_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.head_valid(head_valid),
		.head      (head)
	);

	srm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule
